// ===== sv/ura_pkg.sv =====
// shared types and constants for the ultrasonic range alarm
`timescale 1ns / 1ps
`default_nettype none

package ura_pkg;

  localparam int CNT_W      = 20;
  localparam int DIST_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0]  CNT_MAX  = 20'hFFFFF;
  localparam logic [10:0]       DIST_Q16 = 11'd1114;
  localparam logic [DIST_W-1:0] DIST_MAX = 9'd511;

  localparam logic [7:0]        TRIGGER_TICKS_RST = 8'd30;
  localparam logic [CNT_W-1:0]  RISE_TIMEOUT_RST  = 20'd80000;
  localparam logic [15:0]       ECHO_LIMIT_RST    = 16'd60000;
  localparam logic [DIST_W-1:0] BUZZER_BELOW_RST  = 9'd10;
  localparam logic [DIST_W-1:0] WARNING_MOST_RST  = 9'd20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_ERR = 2'd1,
    ST_FAR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER_TICKS = 3'd0,
    CFG_RISE_TIMEOUT  = 3'd1,
    CFG_ECHO_LIMIT    = 3'd2,
    CFG_BUZZER_BELOW  = 3'd3,
    CFG_WARNING_MOST  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic echo_level;
    logic start_request;
  } in_item_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        status;
    logic [DIST_W-1:0] distance_cm;
    logic              distance_changed;
    logic              buzzer_on;
    logic              warning_on;
  } out_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] cm;
    logic              changed;
    logic              buzzer;
    logic              warning;
  } dist_info_t;

endpackage

`default_nettype wire

// ===== sv/ura_dist.sv =====
// echo tick count to centimetres, with alarm compares
`timescale 1ns / 1ps
`default_nettype none

module ura_dist (
  input  wire logic [15:0]                 count,
  input  wire logic [ura_pkg::DIST_W-1:0]  buzzer_below,
  input  wire logic [ura_pkg::DIST_W-1:0]  warning_most,
  input  wire logic [ura_pkg::DIST_W-1:0]  last_dist,
  output ura_pkg::dist_info_t              info
);
  import ura_pkg::*;

  logic [25:0] prod;
  logic [9:0]  cm_raw;
  logic [DIST_W-1:0] cm;

  // half the ticks times the q16 scale
  assign prod   = 26'(count[15:1]) * 26'(DIST_Q16);
  assign cm_raw = prod[25:16];
  assign cm     = cm_raw[9] ? DIST_MAX : cm_raw[DIST_W-1:0];

  always_comb begin
    info.cm      = cm;
    info.changed = (cm != last_dist);
    info.buzzer  = (cm < buzzer_below);
    info.warning = (cm <= warning_most);
  end

endmodule

`default_nettype wire

// ===== sv/ultrasonic_range_alarm.sv =====
// ultrasonic rangefinder with proximity buzzer and warning, one tick per request
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_item_t (echo level, start)
//   out_     output     out_valid / out_ready out_item_t (trigger, status, distance, alarms)
//   cfg_     input      cfg_wr_en             cfg_idx, cfg_wdata
//
// one request is taken every cycle while in_ready is high; its result is in the output register on the next cycle
// the phase counter and alarm state update at the edge that takes the request
// in_ready drops only while a result waits and out_ready is low
// synchronous active-low reset returns to idle with all registers but the output data at their defaults
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_range_alarm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire ura_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output ura_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ura_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ura_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ura_pkg::*;

  logic [7:0]        trigger_ticks_r;
  logic [CNT_W-1:0]  rise_timeout_r;
  logic [15:0]       echo_limit_r;
  logic [DIST_W-1:0] buzzer_below_r;
  logic [DIST_W-1:0] warning_most_r;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0] last_dist_r, last_dist_nxt;
  logic              buzzer_r, buzzer_nxt;
  logic              warning_r, warning_nxt;

  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_fire;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  echo_limit_ext;
  logic              trig, done;
  status_t           status;
  logic [DIST_W-1:0] dist_val;
  logic              changed;
  dist_info_t        dinfo;

  assign in_ready       = !out_valid_r || out_ready;
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign cnt_inc        = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign echo_limit_ext = {4'd0, echo_limit_r};

  ura_dist u_dist (
    .count        (cnt_r[15:0]),
    .buzzer_below (buzzer_below_r),
    .warning_most (warning_most_r),
    .last_dist    (last_dist_r),
    .info         (dinfo)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r <= TRIGGER_TICKS_RST;
      rise_timeout_r  <= RISE_TIMEOUT_RST;
      echo_limit_r    <= ECHO_LIMIT_RST;
      buzzer_below_r  <= BUZZER_BELOW_RST;
      warning_most_r  <= WARNING_MOST_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx)
        CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[7:0];
        CFG_RISE_TIMEOUT:  rise_timeout_r  <= cfg_wdata[CNT_W-1:0];
        CFG_ECHO_LIMIT:    echo_limit_r    <= cfg_wdata[15:0];
        CFG_BUZZER_BELOW:  buzzer_below_r  <= cfg_wdata[DIST_W-1:0];
        CFG_WARNING_MOST:  warning_most_r  <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // measurement sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      last_dist_r <= '0;
      buzzer_r    <= 1'b0;
      warning_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      last_dist_r <= last_dist_nxt;
      buzzer_r    <= buzzer_nxt;
      warning_r   <= warning_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    last_dist_nxt = last_dist_r;
    buzzer_nxt    = buzzer_r;
    warning_nxt   = warning_r;
    trig          = 1'b0;
    done          = 1'b0;
    status        = ST_OK;
    dist_val      = '0;
    changed       = 1'b0;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_data.start_request) begin
          phase_nxt = PH_TRIG;
          cnt_nxt   = CNT_W'(1);
          trig      = 1'b1;
        end
      end
      PH_TRIG: begin
        if (cnt_r >= {12'd0, trigger_ticks_r}) begin
          phase_nxt = PH_WAIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          trig    = 1'b1;
        end
      end
      PH_WAIT: begin
        if (in_data.echo_level) begin
          phase_nxt = PH_MEAS;
          cnt_nxt   = CNT_W'(1);
          if (echo_limit_r == '0) begin
            done   = 1'b1;
            status = ST_FAR;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= rise_timeout_r) begin
            done   = 1'b1;
            status = ST_ERR;
          end
        end
      end
      PH_MEAS: begin
        if (in_data.echo_level) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > echo_limit_ext) begin
            done   = 1'b1;
            status = ST_FAR;
          end
        end else begin
          done = 1'b1;
          if (cnt_r > echo_limit_ext) begin
            status = ST_FAR;
          end else begin
            status   = ST_OK;
            dist_val = dinfo.cm;
          end
        end
      end
      default: ;
    endcase

    if (done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      case (status)
        ST_OK: begin
          changed       = dinfo.changed;
          last_dist_nxt = dinfo.cm;
          buzzer_nxt    = dinfo.buzzer;
          warning_nxt   = dinfo.warning;
        end
        ST_ERR: begin
          buzzer_nxt = 1'b0;
        end
        default: begin
          buzzer_nxt  = 1'b0;
          warning_nxt = 1'b0;
        end
      endcase
    end

    out_data_nxt.trigger_level    = trig;
    out_data_nxt.busy_res         = (phase_nxt != PH_IDLE);
    out_data_nxt.done_res         = done;
    out_data_nxt.status           = status;
    out_data_nxt.distance_cm      = dist_val;
    out_data_nxt.distance_changed = changed;
    out_data_nxt.buzzer_on        = buzzer_nxt;
    out_data_nxt.warning_on       = warning_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_idle_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cnt_r == '0)
    else $error("counter not clear in idle");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request left no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("finished measurement still busy");

  a_dist_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (!out_data_r.done_res || out_data_r.status != ST_OK)
      |-> out_data_r.distance_cm == '0 && !out_data_r.distance_changed)
    else $error("distance reported without ok result");

  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.trigger_level |-> out_data_r.busy_res)
    else $error("trigger driven while idle");

endmodule

`default_nettype wire
